### rtl/core/sstw_pkg.sv
// shared types, constants and the digit-to-segment decode for the two-wire display serializer
// no dependencies; used by every file under rtl/core
package sstw_pkg;

  localparam int unsigned NUM_PAT = 4;

  localparam logic [7:0] CMD_DATA = 8'h40;  // data command, auto address increment
  localparam logic [7:0] CMD_ADDR = 8'hC0;  // address command, first digit
  localparam logic [7:0] CMD_DISP = 8'h8F;  // display on, full brightness
  localparam logic [7:0] DOT_MASK = 8'b1000_0000;

  localparam logic [1:0] FRAME_DATA = 2'd0;
  localparam logic [1:0] FRAME_ADDR = 2'd1;
  localparam logic [1:0] FRAME_LAST = 2'd2;

  localparam logic [3:0] BIT_ACK = 4'd8;  // bit slot after the eight data bits
  localparam logic [2:0] LAST_ADDR_BYTE = 3'(NUM_PAT);

  typedef enum logic [2:0] {
    SEG_START = 3'b001,
    SEG_BYTE  = 3'b010,
    SEG_STOP  = 3'b100
  } seq_seg_e;

  typedef struct packed {
    logic       op;
    logic [3:0] digit_first;
    logic [3:0] digit_second;
    logic [3:0] digit_third;
    logic [3:0] digit_fourth;
    logic       dot_on;
  } in_t;

  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic busy_res;
    logic accepted;
  } out_t;

  // decoded item as held in the queue
  typedef struct packed {
    logic                          show;
    logic [NUM_PAT-1:0][7:0]       pat;
  } cmd_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] code);
    logic [7:0] p;
    unique case (code)
      4'd0:    p = 8'b0011_1111;
      4'd1:    p = 8'b0000_0110;
      4'd2:    p = 8'b0101_1011;
      4'd3:    p = 8'b0100_1111;
      4'd4:    p = 8'b0110_0110;
      4'd5:    p = 8'b0110_1101;
      4'd6:    p = 8'b0111_1101;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;  // ten and above are blank
    endcase
    return p;
  endfunction

endpackage

### rtl/core/sstw_front.sv
// front end: classifies an incoming transaction and maps its digits to segment patterns
// depends on sstw_pkg
module sstw_front (
  input  sstw_pkg::in_t  item_i,
  output sstw_pkg::cmd_t cmd_o
);

  always_comb begin
    cmd_o.show   = item_i.op;
    cmd_o.pat[0] = sstw_pkg::seg_pattern(item_i.digit_first);
    cmd_o.pat[1] = sstw_pkg::seg_pattern(item_i.digit_second)
                 | (item_i.dot_on ? sstw_pkg::DOT_MASK : 8'h00);
    cmd_o.pat[2] = sstw_pkg::seg_pattern(item_i.digit_third);
    cmd_o.pat[3] = sstw_pkg::seg_pattern(item_i.digit_fourth);
  end

endmodule

### rtl/core/sstw_queue.sv
// short fifo of decoded commands between front end and sequencer
// depends on sstw_pkg
module sstw_queue #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sstw_pkg::cmd_t entry_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output sstw_pkg::cmd_t entry_o
);

  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  sstw_pkg::cmd_t  mem_q [QueueDepth];
  logic [IdxW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == IdxW'(QueueDepth - 1)) ? '0 : wr_q + IdxW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == IdxW'(QueueDepth - 1)) ? '0 : rd_q + IdxW'(1);
      end
    end
  end

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

endmodule

### rtl/core/sstw_back.sv
// back end: pin sequencer that runs the three frames and the result output register
// depends on sstw_pkg
module sstw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  sstw_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sstw_pkg::out_t out_o
);

  localparam logic [1:0] START_LAST = 2'd2;
  localparam logic [1:0] STOP_LAST  = 2'd3;

  logic [sstw_pkg::NUM_PAT-1:0][7:0] pat_q, pat_d;
  logic                 sending_q, sending_d;
  logic                 clk_pin_q, clk_pin_d;
  logic                 dio_pin_q, dio_pin_d;
  sstw_pkg::seq_seg_e   seg_q, seg_d;
  logic [1:0]           frm_q, frm_d;
  logic [1:0]           pos_q, pos_d;
  logic [2:0]           byte_q, byte_d;
  logic [3:0]           bit_q, bit_d;
  logic [1:0]           ph_q, ph_d;
  logic                 out_valid_q, out_valid_d;
  sstw_pkg::out_t       out_q;

  logic       start, step, last_byte;
  logic [7:0] cur_byte;
  logic [1:0] pat_idx;

  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign start     = cmd_pop_o && cmd_i.show && !sending_q;
  assign step      = cmd_pop_o && !cmd_i.show && sending_q;
  assign pat_idx   = 2'(byte_q - 3'd1);

  always_comb begin
    unique case (frm_q)
      sstw_pkg::FRAME_DATA: cur_byte = sstw_pkg::CMD_DATA;
      sstw_pkg::FRAME_ADDR: cur_byte = (byte_q == 3'd0) ? sstw_pkg::CMD_ADDR : pat_q[pat_idx];
      default:              cur_byte = sstw_pkg::CMD_DISP;
    endcase
    last_byte = (frm_q == sstw_pkg::FRAME_ADDR) ? (byte_q == sstw_pkg::LAST_ADDR_BYTE) : 1'b1;
  end

  always_comb begin
    pat_d     = pat_q;
    sending_d = sending_q;
    clk_pin_d = clk_pin_q;
    dio_pin_d = dio_pin_q;
    seg_d     = seg_q;
    frm_d     = frm_q;
    pos_d     = pos_q;
    byte_d    = byte_q;
    bit_d     = bit_q;
    ph_d      = ph_q;
    if (start) begin
      pat_d     = cmd_i.pat;
      sending_d = 1'b1;
      seg_d     = sstw_pkg::SEG_START;
      frm_d     = sstw_pkg::FRAME_DATA;
      pos_d     = '0;
      byte_d    = '0;
      bit_d     = '0;
      ph_d      = '0;
    end else if (step) begin
      unique case (seg_q)
        sstw_pkg::SEG_START: begin
          // clock high, data high, then data low
          unique case (pos_q)
            2'd0:    clk_pin_d = 1'b1;
            2'd1:    dio_pin_d = 1'b1;
            default: dio_pin_d = 1'b0;
          endcase
          if (pos_q == START_LAST) begin
            seg_d  = sstw_pkg::SEG_BYTE;
            pos_d  = '0;
            byte_d = '0;
            bit_d  = '0;
            ph_d   = '0;
          end else begin
            pos_d = pos_q + 2'd1;
          end
        end
        sstw_pkg::SEG_BYTE: begin
          if (bit_q == sstw_pkg::BIT_ACK) begin
            // acknowledge clock, display answer is not sampled
            if (ph_q == 2'd0) begin
              clk_pin_d = 1'b0;
              ph_d      = 2'd1;
            end else begin
              clk_pin_d = 1'b1;
              ph_d      = '0;
              bit_d     = '0;
              if (last_byte) begin
                seg_d = sstw_pkg::SEG_STOP;
                pos_d = '0;
              end else begin
                byte_d = byte_q + 3'd1;
              end
            end
          end else begin
            unique case (ph_q)
              2'd0: begin
                clk_pin_d = 1'b0;
                ph_d      = 2'd1;
              end
              2'd1: begin
                dio_pin_d = cur_byte[bit_q[2:0]];
                ph_d      = 2'd2;
              end
              default: begin
                clk_pin_d = 1'b1;
                ph_d      = '0;
                bit_d     = bit_q + 4'd1;
              end
            endcase
          end
        end
        sstw_pkg::SEG_STOP: begin
          unique case (pos_q)
            2'd0:    clk_pin_d = 1'b0;
            2'd1:    dio_pin_d = 1'b0;
            2'd2:    clk_pin_d = 1'b1;
            default: dio_pin_d = 1'b1;
          endcase
          if (pos_q == STOP_LAST) begin
            pos_d  = '0;
            byte_d = '0;
            seg_d  = sstw_pkg::SEG_START;
            if (frm_q == sstw_pkg::FRAME_LAST) begin
              sending_d = 1'b0;
              frm_d     = sstw_pkg::FRAME_DATA;
            end else begin
              frm_d = frm_q + 2'd1;
            end
          end else begin
            pos_d = pos_q + 2'd1;
          end
        end
        default: seg_d = sstw_pkg::SEG_START;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    if (cmd_pop_o) begin
      out_q.clock_level <= clk_pin_d;
      out_q.data_level  <= dio_pin_d;
      out_q.busy_res    <= sending_d;
      out_q.accepted    <= start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q   <= 1'b0;
      clk_pin_q   <= 1'b0;
      dio_pin_q   <= 1'b0;
      seg_q       <= sstw_pkg::SEG_START;
      frm_q       <= sstw_pkg::FRAME_DATA;
      pos_q       <= '0;
      byte_q      <= '0;
      bit_q       <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sending_q   <= sending_d;
      clk_pin_q   <= clk_pin_d;
      dio_pin_q   <= dio_pin_d;
      seg_q       <= seg_d;
      frm_q       <= frm_d;
      pos_q       <= pos_d;
      byte_q      <= byte_d;
      bit_q       <= bit_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // sequencer rests at the top of the first frame whenever idle
  a_idle_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (seg_q == sstw_pkg::SEG_START && frm_q == sstw_pkg::FRAME_DATA
                    && pos_q == 2'd0))
    else $error("sequencer not at home position while idle");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_q <= sstw_pkg::BIT_ACK) && (ph_q != 2'd3)
    && (bit_q != sstw_pkg::BIT_ACK || ph_q <= 2'd1))
    else $error("bit or phase counter out of range");

  a_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frm_q == sstw_pkg::FRAME_ADDR) ? (byte_q <= sstw_pkg::LAST_ADDR_BYTE) : (byte_q == 3'd0))
    else $error("byte index out of range for frame");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.accepted) |-> out_q.busy_res)
    else $error("show accepted but busy not reported");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q) && !$past(cmd_pop_o)))
    else $error("result register overwritten while stalled");

endmodule

### rtl/core/seven_segment_two_wire_serializer_top.sv
// top level of the two-wire seven-segment serializer: front end, command queue, pin sequencer
// depends on sstw_pkg, sstw_front, sstw_queue and sstw_back
//
// usage
//   input channel (in_valid_i / in_stall_o / in_i): each transaction is either a tick
//   (op = 0) or a show request (op = 1) carrying four digit codes and the dot flag.
//   a show taken while idle latches the patterns and starts the sequence of 203 pin
//   writes; a show while busy is dropped. every tick while busy makes one pin write.
//   output channel (out_valid_o / out_stall_i / out_o): exactly one result transaction
//   per input transaction, in order, with the pin levels after it, busy and accepted.
// timing
//   one transaction per clock sustained in both directions while the receiver does not
//   stall. a result passes two registers on its way: the command queue, then the
//   sequencer's result register, which feeds the output. the sequencer's counter
//   update is the single step per cycle that sets this rate.
// stalls and reset
//   a stalled result holds in its register while the queue keeps absorbing input;
//   in_stall_o rises only once the queue is full. reset empties the queue, drops
//   both pins low and leaves the sequencer idle.
module seven_segment_two_wire_serializer_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sstw_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sstw_pkg::out_t out_o
);

  sstw_pkg::cmd_t front_cmd, queue_cmd;
  logic           queue_full, queue_valid, queue_pop, queue_push;

  sstw_front u_front (
    .item_i (in_i),
    .cmd_o  (front_cmd)
  );

  assign queue_push = in_valid_i && !queue_full;
  assign in_stall_o = queue_full;

  sstw_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .entry_i (front_cmd),
    .pop_i   (queue_pop),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .entry_o (queue_cmd)
  );

  sstw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

### dv/sstw_pin_checker.sv
// result checker for the two-wire seven-segment serializer: predicts the pin levels after
// every accepted input transaction and compares them with the output channel, in order
// depends on sstw_pkg; also holds sstw_tb_pkg, which tb_top shares
package sstw_tb_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SHOW = 1'b1;

  localparam int unsigned SEQ_WRITES = 203;  // pin writes in one full display update

endpackage

module sstw_pin_checker
  import sstw_pkg::*;
  import sstw_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WRITES_SHORT    = 33;   // start, one byte, stop
  localparam int unsigned WRITES_LONG     = 137;  // start, address plus four patterns, stop
  localparam int unsigned WRITES_PER_BYTE = 26;   // eight bits of three writes, ack clock
  localparam int unsigned MAX_REPORTS     = 10;

  localparam logic [7:0] SEG_MAP [11] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h00
  };

  logic [7:0] pat_bank [NUM_PAT];
  logic [7:0] step_cnt;
  logic       clk_lvl;
  logic       dio_lvl;
  logic       busy;

  out_t pin_levels_due [$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  function automatic logic [7:0] to_segments(input logic [3:0] code);
    return (code > 4'd10) ? SEG_MAP[10] : SEG_MAP[code];
  endfunction

  function automatic logic [7:0] frame_byte(input logic [1:0] frame, input int unsigned idx);
    if (frame == FRAME_DATA) return CMD_DATA;
    if (frame == FRAME_LAST) return CMD_DISP;
    if (idx == 0) return CMD_ADDR;
    return pat_bank[(idx - 1) % NUM_PAT];
  endfunction

  // one pin write of the bit-banged sequence, s counts from zero
  function automatic void pin_write(input int unsigned s);
    logic [1:0]  frame;
    int unsigned t;
    int unsigned nbytes;
    int unsigned r;
    logic [7:0]  b;
    if (s < WRITES_SHORT) begin
      frame  = FRAME_DATA;
      t      = s;
      nbytes = 1;
    end else if (s < WRITES_SHORT + WRITES_LONG) begin
      frame  = FRAME_ADDR;
      t      = s - WRITES_SHORT;
      nbytes = NUM_PAT + 1;
    end else begin
      frame  = FRAME_LAST;
      t      = s - WRITES_SHORT - WRITES_LONG;
      nbytes = 1;
    end
    if (t < 3) begin
      // start: clock high, data high, data low
      case (t)
        0:       clk_lvl = 1'b1;
        1:       dio_lvl = 1'b1;
        default: dio_lvl = 1'b0;
      endcase
    end else if (t < 3 + WRITES_PER_BYTE * nbytes) begin
      r = (t - 3) % WRITES_PER_BYTE;
      b = frame_byte(frame, (t - 3) / WRITES_PER_BYTE);
      if (r < 24) begin
        case (r % 3)
          0:       clk_lvl = 1'b0;
          1:       dio_lvl = b[r / 3];
          default: clk_lvl = 1'b1;
        endcase
      end else begin
        clk_lvl = (r == 25);  // acknowledge clock, low then high
      end
    end else begin
      // stop: clock low, data low, clock high, data high
      case (t - 3 - WRITES_PER_BYTE * nbytes)
        0:       clk_lvl = 1'b0;
        1:       dio_lvl = 1'b0;
        2:       clk_lvl = 1'b1;
        default: dio_lvl = 1'b1;
      endcase
    end
  endfunction

  function automatic out_t display_step(input in_t txn);
    out_t        res;
    int unsigned s;
    res.accepted = 1'b0;
    if (txn.op == OP_SHOW) begin
      if (!busy) begin
        pat_bank[0] = to_segments(txn.digit_first);
        pat_bank[1] = to_segments(txn.digit_second) | (txn.dot_on ? DOT_MASK : 8'h00);
        pat_bank[2] = to_segments(txn.digit_third);
        pat_bank[3] = to_segments(txn.digit_fourth);
        step_cnt     = 8'd0;
        busy         = 1'b1;
        res.accepted = 1'b1;
      end
    end else if (busy) begin
      s = (step_cnt >= SEQ_WRITES) ? SEQ_WRITES - 1 : step_cnt;
      pin_write(s);
      s++;
      if (s >= SEQ_WRITES) begin
        busy     = 1'b0;
        step_cnt = 8'd0;
      end else begin
        step_cnt = 8'(s);
      end
    end
    res.clock_level = clk_lvl;
    res.data_level  = dio_lvl;
    res.busy_res    = busy;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input out_t want, input out_t got);
    if (mismatches_o < MAX_REPORTS) begin
      $display("%0t ns: %s: expected clk=%0b dio=%0b busy=%0b acc=%0b, got clk=%0b dio=%0b busy=%0b acc=%0b",
               $realtime, what, want.clock_level, want.data_level, want.busy_res, want.accepted,
               got.clock_level, got.data_level, got.busy_res, got.accepted);
    end
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      foreach (pat_bank[i]) pat_bank[i] = 8'h00;
      step_cnt = 8'd0;
      clk_lvl  = 1'b0;
      dio_lvl  = 1'b0;
      busy     = 1'b0;
      pin_levels_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pin_levels_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, out_i);
        end else begin
          want = pin_levels_due.pop_front();
          if (out_i.clock_level !== want.clock_level || out_i.data_level !== want.data_level ||
              out_i.busy_res !== want.busy_res || out_i.accepted !== want.accepted) begin
            report_mismatch("result mismatch", want, out_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) pin_levels_due.push_back(display_step(in_i));
    end
    pending_o = pin_levels_due.size();
  end

endmodule

### dv/tb_top.sv
// top of the serializer regression: clock, reset, stimulus on both channels and the verdict
// depends on sstw_pkg, sstw_tb_pkg, sstw_pin_checker and seven_segment_two_wire_serializer_top
module tb_top;
  import sstw_pkg::*;
  import sstw_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS     = 650;
  localparam int unsigned HOLD_AT   = 200;  // receiver holds off from here
  localparam int unsigned PAUSE_AT  = 420;  // sender drains the block here
  localparam int unsigned QUIET_AT  = 560;  // no more idling on either side
  localparam int unsigned LONG_HOLD = 40;
  localparam int unsigned LIMIT     = 200000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned sent = 0;
  int unsigned seq_left = 0;  // ticks still owed to the running display update
  int unsigned cycle_cnt = 0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic        send_noisy = 1'b1;
  logic        recv_noisy = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seven_segment_two_wire_serializer_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data)
  );

  sstw_pin_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_i         (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_i        (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // offer one transaction and return just after the edge that takes it
  task automatic send_txn(input in_t txn);
    logic taken;
    if ($urandom_range(0, 63) == 0) send_noisy = !send_noisy;
    if (!quiet && send_noisy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= txn;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    sent++;
    if (txn.op == OP_SHOW && seq_left == 0) seq_left = SEQ_WRITES;
    else if (txn.op == OP_TICK && seq_left != 0) seq_left--;
  endtask

  function automatic in_t random_txn(input logic op);
    in_t txn;
    txn    = in_t'($urandom);
    txn.op = op;
    return txn;
  endfunction

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) recv_noisy = !recv_noisy;
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && recv_noisy && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("seven_segment_two_wire_serializer_top regression: fail");
    $finish;
  end

  initial begin
    in_t        txn;
    logic [3:0] code_ctr;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ticks while idle leave the pins alone
    txn = '1;
    txn.op = OP_TICK;
    send_txn(txn);
    send_txn('0);
    // blank, saturated and dotted digits, then shows while busy are dropped
    send_txn('{OP_SHOW, 4'hF, 4'hA, 4'h0, 4'h8, 1'b1});
    send_txn('{OP_SHOW, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0});
    send_txn('{OP_SHOW, 4'h9, 4'hB, 4'h1, 4'h7, 1'b1});
    repeat (18) send_txn(random_txn(OP_TICK));

    code_ctr = 4'($urandom);
    while (sent < ITEMS) begin
      if (sent >= QUIET_AT) quiet = 1'b1;
      if (sent == HOLD_AT) hold_req = 1'b1;
      if (sent == PAUSE_AT) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
      end
      if (seq_left == 0 && $urandom_range(0, 7) != 0) begin
        // walk the digit codes so that every code turns up across the updates
        txn = '{OP_SHOW, code_ctr, code_ctr + 4'd1, code_ctr + 4'd2, code_ctr + 4'd3,
                1'($urandom_range(0, 1))};
        code_ctr += 4'd4;
      end else if (seq_left != 0 && $urandom_range(0, 24) == 0) begin
        txn = random_txn(OP_SHOW);
      end else begin
        txn = random_txn(OP_TICK);
      end
      send_txn(txn);
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("seven_segment_two_wire_serializer_top regression: pass");
    end else begin
      $display("seven_segment_two_wire_serializer_top regression: fail");
    end
    $finish;
  end

endmodule
